FILE: hw/rtl/srq_pkg.sv
// Shared types and constants for the stride scheduler ready queue.
// No dependencies; the top level refers to it by scoped names.
package srq_pkg;

  localparam int SLOTS = 64;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PROC_W = 6;
  localparam int PROCS = 1 << PROC_W;
  localparam int PRIO_W = 16;
  localparam int BIG_W = 32;
  localparam int STRIDE_W = 64;
  localparam int DIV_STEPS = BIG_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [BIG_W-1:0] PASS_CONST_RST = 32'd65536;
  localparam logic [PRIO_W-1:0] PRIO_MIN = 16'd2;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP = 1'b1;

  localparam logic [1:0] STAT_PUSHED = 2'd0;
  localparam logic [1:0] STAT_POPPED = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;
  localparam logic [1:0] STAT_OVERFLOW = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_PRIO,
    ST_DIV,
    ST_UPD,
    ST_MOVE,
    ST_DONE
  } state_t;

endpackage

FILE: hw/rtl/stride_scheduler_ready_queue.sv
// Stride scheduler ready queue: circular slot queue, stride and priority tables,
// head-to-tail minimum scan and a bit-serial divider. Uses srq_pkg.
//
//   channel | ports                                              | dir
//   --------+----------------------------------------------------+-----
//   in      | in_valid in_ready in_command in_process in_priority_req | in
//   out     | out_valid out_ready out_chosen out_status          | out
//   cfg     | cfg_valid cfg_ready cfg_pass_const                 | in
//
// One request at a time. A push or a rejected request passes from the exec state to the
// done state, which loads its result; a pop first scans the n queued slots, reading one
// slot per cycle through the slot and stride memory ports and then draining the read
// pipe, then the divider computes pass_const / priority bit-serially. The block is ready
// again in the same cycle that its result is loaded into the output register.
// Synchronous reset clears control and the stride valid bits. A waiting result is held
// in the output register and the next request is accepted meanwhile; its own result
// then waits in the done state until the output register frees up.
module stride_scheduler_ready_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_command,
  input  logic [srq_pkg::PROC_W-1:0]    in_process,
  input  logic [srq_pkg::PRIO_W-1:0]    in_priority_req,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [srq_pkg::PROC_W-1:0]    out_chosen,
  output logic [1:0]                    out_status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [srq_pkg::BIG_W-1:0]     cfg_pass_const
);

  localparam int IW = srq_pkg::IDX_W;
  localparam int PW = srq_pkg::PROC_W;
  localparam int QW = srq_pkg::PRIO_W;
  localparam int BW = srq_pkg::BIG_W;
  localparam int SW = srq_pkg::STRIDE_W;
  localparam int CW = srq_pkg::DIV_CNT_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(srq_pkg::SLOTS - 1);
  localparam logic [CW-1:0] LAST_STEP = CW'(srq_pkg::DIV_STEPS - 1);

  // memories
  logic [PW-1:0] slot_mem [srq_pkg::SLOTS];
  logic [SW-1:0] stride_mem [srq_pkg::PROCS];
  logic [QW-1:0] prio_mem [srq_pkg::PROCS];
  logic [srq_pkg::PROCS-1:0] sval_r;

  srq_pkg::state_t state_r, state_nxt;

  logic [BW-1:0] pass_const_r;
  logic [IW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic          empty_r, empty_nxt;
  logic          req_cmd_r;
  logic [PW-1:0] req_proc_r;
  logic [QW-1:0] req_prio_r;

  logic [IW-1:0] scan_i_r, scan_i_nxt;
  logic          issuing_r, issuing_nxt;
  logic          p1_v_r, p1_v_nxt;
  logic [IW-1:0] p1_idx_r;
  logic          p2_v_r;
  logic [IW-1:0] p2_idx_r;
  logic [PW-1:0] p2_proc_r;

  logic [PW-1:0] slot_rd_r;
  logic [SW-1:0] stride_rd_r;
  logic          sval_rd_r;
  logic [QW-1:0] prio_rd_r;

  logic [SW-1:0] best_r, best_nxt;
  logic [PW-1:0] best_proc_r, best_proc_nxt;
  logic [IW-1:0] best_slot_r, best_slot_nxt;

  logic [BW-1:0] quo_r, quo_nxt;
  logic [QW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] div_cnt_r, div_cnt_nxt;

  logic [PW-1:0] res_chosen_r, res_chosen_nxt;
  logic [1:0]    res_status_r, res_status_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [PW-1:0] out_chosen_r, out_chosen_nxt;
  logic [1:0]    out_status_r, out_status_nxt;

  logic          full;
  logic          out_free;
  logic          scan_drained;
  logic [IW-1:0] scan_next;
  logic [IW-1:0] head_step;
  logic [SW-1:0] cand;
  logic [QW-1:0] dvsr;
  logic [QW:0]   rem_sh;
  logic          ge;
  logic [QW-1:0] req_prio_clamp;

  logic          slot_we;
  logic [IW-1:0] slot_wa, slot_ra;
  logic [PW-1:0] slot_wd;
  logic          prio_we;
  logic          stride_we;
  logic [SW-1:0] stride_wd;

  assign full         = !empty_r && (head_r == tail_r);
  assign out_free     = !out_valid_r || out_ready;
  assign scan_drained = !issuing_r && !p1_v_r && !p2_v_r;
  assign scan_next    = (scan_i_r == LAST_IDX) ? '0 : scan_i_r + IW'(1);
  assign head_step    = (head_r == LAST_IDX) ? '0 : head_r + IW'(1);
  assign cand         = sval_rd_r ? stride_rd_r : '0;
  assign dvsr         = (prio_rd_r < srq_pkg::PRIO_MIN) ? srq_pkg::PRIO_MIN : prio_rd_r;
  assign rem_sh       = {rem_r, quo_r[BW-1]};
  assign ge           = rem_sh >= {1'b0, dvsr};
  assign req_prio_clamp = (req_prio_r < srq_pkg::PRIO_MIN) ? srq_pkg::PRIO_MIN : req_prio_r;

  assign in_ready   = (state_r == srq_pkg::ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_chosen = out_chosen_r;
  assign out_status = out_status_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      srq_pkg::ST_IDLE: if (in_valid) state_nxt = srq_pkg::ST_EXEC;
      srq_pkg::ST_EXEC: begin
        if (req_cmd_r == srq_pkg::CMD_POP && !empty_r) state_nxt = srq_pkg::ST_SCAN;
        else state_nxt = srq_pkg::ST_DONE;
      end
      srq_pkg::ST_SCAN: if (scan_drained) state_nxt = srq_pkg::ST_PRIO;
      srq_pkg::ST_PRIO: state_nxt = srq_pkg::ST_DIV;
      srq_pkg::ST_DIV:  if (div_cnt_r == LAST_STEP) state_nxt = srq_pkg::ST_UPD;
      srq_pkg::ST_UPD:  state_nxt = srq_pkg::ST_MOVE;
      srq_pkg::ST_MOVE: state_nxt = srq_pkg::ST_DONE;
      srq_pkg::ST_DONE: if (out_free) state_nxt = srq_pkg::ST_IDLE;
      default:          state_nxt = srq_pkg::ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    empty_nxt      = empty_r;
    scan_i_nxt     = scan_i_r;
    issuing_nxt    = 1'b0;
    p1_v_nxt       = 1'b0;
    best_nxt       = best_r;
    best_proc_nxt  = best_proc_r;
    best_slot_nxt  = best_slot_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    div_cnt_nxt    = div_cnt_r;
    res_chosen_nxt = res_chosen_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_chosen_nxt = out_chosen_r;
    out_status_nxt = out_status_r;
    slot_we        = 1'b0;
    slot_wa        = tail_r;
    slot_wd        = req_proc_r;
    slot_ra        = head_r;
    prio_we        = 1'b0;
    stride_we      = 1'b0;
    stride_wd      = best_r + {{(SW-BW){1'b0}}, quo_r};

    unique case (state_r)
      srq_pkg::ST_EXEC: begin
        res_chosen_nxt = '0;
        if (req_cmd_r == srq_pkg::CMD_PUSH) begin
          if (full) begin
            res_status_nxt = srq_pkg::STAT_OVERFLOW;
          end else begin
            res_status_nxt = srq_pkg::STAT_PUSHED;
            slot_we   = 1'b1;
            prio_we   = 1'b1;
            tail_nxt  = (tail_r == LAST_IDX) ? '0 : tail_r + IW'(1);
            empty_nxt = 1'b0;
          end
        end else if (empty_r) begin
          res_status_nxt = srq_pkg::STAT_EMPTY;
        end else begin
          scan_i_nxt  = head_r;
          issuing_nxt = 1'b1;
        end
      end
      srq_pkg::ST_SCAN: begin
        slot_ra = scan_i_r;
        if (issuing_r) begin
          p1_v_nxt    = 1'b1;
          scan_i_nxt  = scan_next;
          // stop once the slot just issued is the last occupied one
          issuing_nxt = (scan_next != tail_r);
        end
        if (p2_v_r && ((p2_idx_r == head_r) || (cand < best_r))) begin
          best_nxt      = cand;
          best_proc_nxt = p2_proc_r;
          best_slot_nxt = p2_idx_r;
        end
      end
      srq_pkg::ST_PRIO: begin
        quo_nxt     = pass_const_r;
        rem_nxt     = '0;
        div_cnt_nxt = '0;
      end
      srq_pkg::ST_DIV: begin
        rem_nxt     = ge ? QW'(rem_sh - {1'b0, dvsr}) : rem_sh[QW-1:0];
        quo_nxt     = {quo_r[BW-2:0], ge};
        div_cnt_nxt = div_cnt_r + CW'(1);
      end
      srq_pkg::ST_UPD: begin
        stride_we = 1'b1;
        slot_ra   = head_r;
      end
      srq_pkg::ST_MOVE: begin
        // refill the freed slot with the head entry
        slot_we        = 1'b1;
        slot_wa        = best_slot_r;
        slot_wd        = slot_rd_r;
        head_nxt       = head_step;
        empty_nxt      = (head_step == tail_r);
        res_chosen_nxt = best_proc_r;
        res_status_nxt = srq_pkg::STAT_POPPED;
      end
      srq_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_chosen_nxt = res_chosen_r;
          out_status_nxt = res_status_r;
        end
      end
      default: begin
      end
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    slot_rd_r <= slot_mem[slot_ra];
  end

  always_ff @(posedge clk) begin
    if (stride_we) stride_mem[best_proc_r] <= stride_wd;
    stride_rd_r <= stride_mem[slot_rd_r];
  end

  always_ff @(posedge clk) begin
    if (prio_we) prio_mem[req_proc_r] <= req_prio_clamp;
    prio_rd_r <= prio_mem[best_proc_r];
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= srq_pkg::ST_IDLE;
      pass_const_r <= srq_pkg::PASS_CONST_RST;
      head_r       <= '0;
      tail_r       <= '0;
      empty_r      <= 1'b1;
      issuing_r    <= 1'b0;
      p1_v_r       <= 1'b0;
      p2_v_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      sval_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_valid && cfg_ready) pass_const_r <= cfg_pass_const;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      empty_r     <= empty_nxt;
      issuing_r   <= issuing_nxt;
      p1_v_r      <= p1_v_nxt;
      p2_v_r      <= p1_v_r;
      out_valid_r <= out_valid_nxt;
      if (stride_we) sval_r[best_proc_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_cmd_r  <= in_command;
      req_proc_r <= in_process;
      req_prio_r <= in_priority_req;
    end
    scan_i_r     <= scan_i_nxt;
    p1_idx_r     <= scan_i_r;
    p2_idx_r     <= p1_idx_r;
    p2_proc_r    <= slot_rd_r;
    sval_rd_r    <= sval_r[slot_rd_r];
    best_r       <= best_nxt;
    best_proc_r  <= best_proc_nxt;
    best_slot_r  <= best_slot_nxt;
    quo_r        <= quo_nxt;
    rem_r        <= rem_nxt;
    div_cnt_r    <= div_cnt_nxt;
    res_chosen_r <= res_chosen_nxt;
    res_status_r <= res_status_nxt;
    out_chosen_r <= out_chosen_nxt;
    out_status_r <= out_status_nxt;
  end

  // checks
  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == srq_pkg::ST_SCAN) |-> !empty_r)
    else $error("scan running on an empty queue");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r |-> (head_r == tail_r))
    else $error("empty queue with head and tail apart");

  a_chosen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != srq_pkg::STAT_POPPED) |-> (out_chosen_r == '0))
    else $error("nonzero process on a result other than pop");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == srq_pkg::ST_DONE)
    else $error("result loaded outside the done state");

endmodule
